// File: hdl/dxt_texture_block_decode_macros.svh
// Assertion helpers for the texture block decoder.
// Both macros sample on clock and stay quiet while reset is high.
`ifndef DXT_TEXTURE_BLOCK_DECODE_MACROS_SVH
`define DXT_TEXTURE_BLOCK_DECODE_MACROS_SVH

// Same-cycle implication
`define DXT_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("dxt decoder: same-cycle check failed");

// Next-cycle implication
`define DXT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("dxt decoder: next-cycle check failed");

`endif

// File: hdl/dxt_pkg.sv
package dxt_pkg;

   // Block format codes; code three decodes as BC1
   typedef enum logic [1:0] {
      FMT_BC1 = 2'd0,
      FMT_BC2 = 2'd1,
      FMT_BC3 = 2'd2
   } fmt_type;

   // Reciprocals for truncating division by small constants
   localparam int RECIP3  = 2731;   // x/3 = (x*2731)>>13 for x < 8192
   localparam int RECIP5  = 3277;   // x/5 = (x*3277)>>14 for x < 16384
   localparam int RECIP7  = 4682;   // x/7 = (x*4682)>>15 for x < 5461
   localparam int RECIP31 = 8457;   // x/31 = (x*8457)>>18 for x < 11407
   localparam int RECIP63 = 16645;  // x/63 = (x*16645)>>20 for x < 17700

   // Six-step alpha mode: last interpolated step, then the zero step
   localparam logic [2:0] SIX_LAST_STEP = 3'd4;
   localparam logic [2:0] SIX_ZERO_STEP = 3'd5;
   localparam logic [2:0] WEIGHT7 = 3'd7;
   localparam logic [2:0] WEIGHT5 = 3'd5;

   localparam logic [3:0] LAST_TEXEL = 4'd15;

   typedef logic [7:0] chan_type;
   typedef chan_type [3:0] cpal_type;       // four palette entries, one channel
   typedef chan_type [5:0] apal_lane_type;  // alpha palette entries 2..7

   // Load strobes for the second and third stages
   typedef struct packed {
      logic ld2;
      logic ld3;
   } stage_ctl_type;

   // Block data handed from the second stage to the texel stage
   typedef struct packed {
      logic [63:0] alpha_half;
      logic [31:0] color_idx;
      fmt_type     fmt;
      logic        four_color;
   } block_type;

   // 5-bit endpoint to 8 bits: v*255/31, truncating
   function automatic chan_type expand5(input logic [4:0] v);
      logic [26:0] p;
      p = 27'(v) * 27'd255 * 27'(RECIP31);
      return p[25:18];
   endfunction

   // 6-bit endpoint to 8 bits: v*255/63, truncating
   function automatic chan_type expand6(input logic [5:0] v);
      logic [28:0] p;
      p = 29'(v) * 29'd255 * 29'(RECIP63);
      return p[27:20];
   endfunction

endpackage

// File: hdl/dxt_texture_block_decode.sv
// A block passes the second stage and the texel stage; each texel then leaves through the output register.
// Throughput: one texel per cycle while rsp_tready is high; the result channel sets the pace.
// A new block is taken while the previous one is still streaming out.
// Reset (synchronous, active high) empties all stages and sets the format to BC1.
// There is no clearing pass; the block takes input in the first cycle after reset.
module dxt_texture_block_decode (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_we,
   input  logic [1:0]   csr_wdata,   // block_format
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,   // alpha_half, color_half
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [39:0]  rsp_tdata,   // red, green, blue, alpha, texel_index, pad
   output logic         rsp_tlast    // last_texel
);
   import dxt_pkg::*;

   `include "dxt_texture_block_decode_macros.svh"

   logic [1:0]    fmt_cfg_ff;
   fmt_type       fmt_eff;
   logic          s2_valid_ff, s2_valid_in;
   block_type     blk_ff, blk_in;
   logic          gt_ff, gt_in;
   logic          s3_free, accept;
   stage_ctl_type ctl;
   logic [63:0]   ah, ch;
   logic [15:0]   c0, c1;
   cpal_type      pal_r, pal_g, pal_b;
   apal_lane_type apal_hi;

   assign ah = req_tdata[63:0];
   assign ch = req_tdata[127:64];
   assign c0 = ch[15:0];
   assign c1 = ch[31:16];

   // Format register; code three decodes as BC1
   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_cfg_ff <= 2'd0;
      end else if (csr_we) begin
         fmt_cfg_ff <= csr_wdata;
      end
   end

   always_comb begin
      case (fmt_cfg_ff)
         FMT_BC2: fmt_eff = FMT_BC2;
         FMT_BC3: fmt_eff = FMT_BC3;
         default: fmt_eff = FMT_BC1;
      endcase
   end

   // Stage flow
   always_comb begin
      req_tready  = !s2_valid_ff || s3_free;
      accept      = req_tvalid && req_tready;
      ctl.ld2     = accept;
      ctl.ld3     = s2_valid_ff && s3_free;
      s2_valid_in = accept ? 1'b1 : (ctl.ld3 ? 1'b0 : s2_valid_ff);
      blk_in.alpha_half = ah;
      blk_in.color_idx  = ch[63:32];
      blk_in.fmt        = fmt_eff;
      blk_in.four_color = (fmt_eff != FMT_BC1) || (c0 > c1);
      gt_in             = ah[7:0] > ah[15:8];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         blk_ff <= blk_in;
         gt_ff  <= gt_in;
      end
   end

   // Colour lanes: red, green, blue
   dxt_color_lane u_lane_r (
      .clock(clock), .ctl(ctl), .wide(1'b0),
      .raw0({1'b0, c0[15:11]}), .raw1({1'b0, c1[15:11]}),
      .four_color(blk_ff.four_color), .pal(pal_r)
   );

   dxt_color_lane u_lane_g (
      .clock(clock), .ctl(ctl), .wide(1'b1),
      .raw0(c0[10:5]), .raw1(c1[10:5]),
      .four_color(blk_ff.four_color), .pal(pal_g)
   );

   dxt_color_lane u_lane_b (
      .clock(clock), .ctl(ctl), .wide(1'b0),
      .raw0({1'b0, c0[4:0]}), .raw1({1'b0, c1[4:0]}),
      .four_color(blk_ff.four_color), .pal(pal_b)
   );

   // Alpha lanes: one per interpolated entry
   for (genvar i = 1; i <= 6; i++) begin : g_alpha
      dxt_alpha_lane u_lane_a (
         .clock(clock), .ctl(ctl), .step(3'(i)),
         .a0(ah[7:0]), .a1(ah[15:8]), .gt(gt_ff),
         .value(apal_hi[i - 1])
      );
   end

   // Texel stage and output register
   dxt_texel_merge u_merge (
      .clock(clock), .reset(reset),
      .s2_valid(s2_valid_ff), .blk(blk_ff),
      .pal_r(pal_r), .pal_g(pal_g), .pal_b(pal_b), .apal_hi(apal_hi),
      .s3_free(s3_free),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast)
   );

   // No bubble inside a block
   `DXT_ASSERT_NEXT(a_no_gap, rsp_tvalid && rsp_tready && !rsp_tlast, rsp_tvalid)
   // Texels of a block come in order
   `DXT_ASSERT_NEXT(a_index_step, rsp_tvalid && rsp_tready && !rsp_tlast,
                    rsp_tdata[35:32] == $past(rsp_tdata[35:32]) + 4'd1)
   // Last mark sits on texel fifteen only
   `DXT_ASSERT_NOW(a_last_index, rsp_tvalid, rsp_tlast == (rsp_tdata[35:32] == LAST_TEXEL))

endmodule

// File: hdl/dxt_color_lane.sv
module dxt_color_lane (
   input  logic                   clock,
   input  dxt_pkg::stage_ctl_type ctl,
   input  logic                   wide,        // green channel: 6-bit endpoints
   input  logic [5:0]             raw0,
   input  logic [5:0]             raw1,
   input  logic                   four_color,  // second-stage flag
   output dxt_pkg::cpal_type      pal
);
   import dxt_pkg::*;

   chan_type    e0_ff, e1_ff, e0_in, e1_in;
   cpal_type    pal_ff, pal_in;
   logic [9:0]  sum_a, sum_b;
   logic [21:0] prod_a, prod_b;
   logic [8:0]  sum_h;

   // Endpoint expansion
   always_comb begin
      e0_in = wide ? expand6(raw0) : expand5(raw0[4:0]);
      e1_in = wide ? expand6(raw1) : expand5(raw1[4:0]);
   end

   // Interpolated entries
   always_comb begin
      sum_a  = {1'b0, e0_ff, 1'b0} + {2'b00, e1_ff};
      sum_b  = {2'b00, e0_ff} + {1'b0, e1_ff, 1'b0};
      prod_a = 22'(sum_a) * 22'(RECIP3);
      prod_b = 22'(sum_b) * 22'(RECIP3);
      sum_h  = {1'b0, e0_ff} + {1'b0, e1_ff};
      pal_in[0] = e0_ff;
      pal_in[1] = e1_ff;
      pal_in[2] = four_color ? prod_a[20:13] : sum_h[8:1];
      pal_in[3] = four_color ? prod_b[20:13] : 8'd0;
   end

   always_ff @(posedge clock) begin
      if (ctl.ld2) begin
         e0_ff <= e0_in;
         e1_ff <= e1_in;
      end
      if (ctl.ld3) begin
         pal_ff <= pal_in;
      end
   end

   assign pal = pal_ff;

endmodule

// File: hdl/dxt_alpha_lane.sv
module dxt_alpha_lane (
   input  logic                   clock,
   input  dxt_pkg::stage_ctl_type ctl,
   input  logic [2:0]             step,   // lane computes alpha entry step+1
   input  logic [7:0]             a0,
   input  logic [7:0]             a1,
   input  logic                   gt,     // second-stage a0 > a1
   output dxt_pkg::chan_type      value
);
   import dxt_pkg::*;

   logic [2:0]  w7, w5;
   logic [10:0] sum7_ff, sum7_in, sum5_ff, sum5_in;
   logic [23:0] prod7;
   logic [22:0] prod5;
   chan_type    six, value_ff, value_in;

   // Weighted endpoint sums
   always_comb begin
      w7 = WEIGHT7 - step;
      w5 = (step <= SIX_LAST_STEP) ? 3'(WEIGHT5 - step) : 3'd0;
      sum7_in = 11'(w7) * 11'(a0) + 11'(step) * 11'(a1);
      sum5_in = 11'(w5) * 11'(a0) + 11'(step) * 11'(a1);
   end

   // Divide by 7 or 5 and choose the mode
   always_comb begin
      prod7 = 24'(sum7_ff) * 24'(RECIP7);
      prod5 = 23'(sum5_ff) * 23'(RECIP5);
      if (step <= SIX_LAST_STEP) begin
         six = prod5[21:14];
      end else if (step == SIX_ZERO_STEP) begin
         six = 8'd0;
      end else begin
         six = 8'd255;
      end
      value_in = gt ? prod7[22:15] : six;
   end

   always_ff @(posedge clock) begin
      if (ctl.ld2) begin
         sum7_ff <= sum7_in;
         sum5_ff <= sum5_in;
      end
      if (ctl.ld3) begin
         value_ff <= value_in;
      end
   end

   assign value = value_ff;

endmodule

// File: hdl/dxt_texel_merge.sv
module dxt_texel_merge (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   s2_valid,
   input  dxt_pkg::block_type     blk,
   input  dxt_pkg::cpal_type      pal_r,
   input  dxt_pkg::cpal_type      pal_g,
   input  dxt_pkg::cpal_type      pal_b,
   input  dxt_pkg::apal_lane_type apal_hi,
   output logic                   s3_free,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [39:0]            rsp_tdata,   // red, green, blue, alpha, texel_index, pad
   output logic                   rsp_tlast
);
   import dxt_pkg::*;

   logic        s3_valid_ff, s3_valid_in;
   logic [3:0]  cnt_ff, cnt_in;
   block_type   blk_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [35:0] rsp_data_ff, rsp_data_in;
   logic        rsp_last_ff, rsp_last_in;
   logic        out_load, adv, done, load3;
   logic [1:0]  ci;
   logic [3:0]  nib;
   logic [47:0] aidx_field;
   logic [5:0]  aidx_pos;
   logic [2:0]  ai;
   chan_type    a_interp, alpha;

   // Stage handshake
   always_comb begin
      out_load = !rsp_valid_ff || rsp_tready;
      adv      = s3_valid_ff && out_load;
      done     = adv && (cnt_ff == LAST_TEXEL);
      s3_free  = !s3_valid_ff || done;
      load3    = s2_valid && s3_free;
   end

   // Texel select
   always_comb begin
      ci         = blk_ff.color_idx[{cnt_ff, 1'b0} +: 2];
      nib        = blk_ff.alpha_half[{cnt_ff, 2'b00} +: 4];
      aidx_field = blk_ff.alpha_half[63:16];
      aidx_pos   = {2'b00, cnt_ff} + {1'b0, cnt_ff, 1'b0};
      ai         = aidx_field[aidx_pos +: 3];
      case (ai)
         3'd0:    a_interp = blk_ff.alpha_half[7:0];
         3'd1:    a_interp = blk_ff.alpha_half[15:8];
         3'd2:    a_interp = apal_hi[0];
         3'd3:    a_interp = apal_hi[1];
         3'd4:    a_interp = apal_hi[2];
         3'd5:    a_interp = apal_hi[3];
         3'd6:    a_interp = apal_hi[4];
         default: a_interp = apal_hi[5];
      endcase
      case (blk_ff.fmt)
         FMT_BC2: alpha = {nib, nib};
         FMT_BC3: alpha = a_interp;
         default: alpha = (ci == 2'd3 && !blk_ff.four_color) ? 8'd0 : 8'd255;
      endcase
      rsp_data_in = {cnt_ff, alpha, pal_b[ci], pal_g[ci], pal_r[ci]};
      rsp_last_in = (cnt_ff == LAST_TEXEL);
   end

   // Next state for control
   always_comb begin
      s3_valid_in  = s3_valid_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      if (adv) begin
         cnt_in = cnt_ff + 4'd1;
      end
      if (load3) begin
         s3_valid_in = 1'b1;
         cnt_in      = 4'd0;
      end else if (done) begin
         s3_valid_in = 1'b0;
      end
      if (out_load) begin
         rsp_valid_in = adv;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff  <= 1'b0;
         cnt_ff       <= 4'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff  <= s3_valid_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (load3) begin
         blk_ff <= blk;
      end
      if (adv) begin
         rsp_data_ff <= rsp_data_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_data_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

// File: test/dxt_texture_block_decode_tb.sv
module dxt_texture_block_decode_tb;
   import dxt_pkg::*;

   localparam int CLK_HIGH      = 6;
   localparam int CLK_LOW       = 6;
   localparam int RESET_CYCLES  = 8;
   localparam int SETTLE_CYCLES = 24;    // idle margin once no texels are outstanding
   localparam int HOLD_CYCLES   = 300;   // long receiver hold-off
   localparam int STALL_LIMIT   = 2000;  // cycles with no transfer before giving up
   localparam int RANDOM_PHASES = 8;
   localparam int BLOCKS_PER_PHASE = 39;
   localparam int PRESSURE_PHASE   = 2;
   localparam int NUM_VECTORS      = 21;
   localparam int MAX_REPORTS      = 40;

   // Format code three has no format of its own; it decodes as BC1
   localparam logic [1:0] FMT_CODE3 = 2'd3;

   // Directed block; rgba packs red in the low byte up to alpha in the high byte
   typedef struct packed {
      logic [1:0]  fmt;
      logic [63:0] alpha_half;
      logic [63:0] color_half;
      logic        known;   // all 16 texels equal rgba
      logic [31:0] rgba;
   } vector_type;

   typedef struct {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
      logic [3:0] pos;
      logic       last;
   } texel_type;

   localparam vector_type VECTORS [NUM_VECTORS] = '{
      // BC1: zero block is three-color mode, index 0 gives opaque black
      '{FMT_BC1, 64'h0, 64'h0, 1'b1, 32'hFF000000},
      // BC1 four-color, white endpoint; alpha half is ignored
      '{FMT_BC1, 64'hFFFFFFFFFFFFFFFF, 64'h00000000_0000FFFF, 1'b1, 32'hFFFFFFFF},
      '{FMT_BC1, 64'h0, 64'hFFFFFFFF_0000FFFF, 1'b1, 32'hFF555555},
      '{FMT_BC1, 64'h0, 64'hAAAAAAAA_0000FFFF, 1'b1, 32'hFFAAAAAA},
      // BC1 three-color: index 3 is transparent black, index 2 the midpoint
      '{FMT_BC1, 64'h0, 64'hFFFFFFFF_FFFF0000, 1'b1, 32'h00000000},
      '{FMT_BC1, 64'h0, 64'hAAAAAAAA_FFFF0000, 1'b1, 32'hFF7F7F7F},
      // equal endpoints select three-color mode
      '{FMT_BC1, 64'h0, 64'hE4E4E4E4_12341234, 1'b0, 32'h0},
      // endpoints one apart select four-color mode
      '{FMT_BC1, 64'h0, 64'h1B1B1B1B_F800F801, 1'b0, 32'h0},
      '{FMT_BC1, 64'hFFFFFFFFFFFFFFFF, 64'hFFFFFFFFFFFFFFFF, 1'b1, 32'h00000000},
      // code three behaves as BC1
      '{FMT_CODE3, 64'h0, 64'hFFFFFFFF_FFFF0000, 1'b1, 32'h00000000},
      '{FMT_CODE3, 64'h0123456789ABCDEF, 64'hE4E4E4E4_07E0F81F, 1'b0, 32'h0},
      // BC2: nibble alpha, always four-color
      '{FMT_BC2, 64'hFFFFFFFFFFFFFFFF, 64'h0, 1'b1, 32'hFF000000},
      '{FMT_BC2, 64'h0, 64'hFFFFFFFF_FFFF0000, 1'b1, 32'h00AAAAAA},
      '{FMT_BC2, 64'hFEDCBA9876543210, 64'hE4E4E4E4_F800001F, 1'b0, 32'h0},
      // BC3: six-step mode, index 0, 7 and 6
      '{FMT_BC3, 64'h0, 64'h0, 1'b1, 32'h00000000},
      '{FMT_BC3, 64'hFFFFFFFFFFFF0000, 64'h0, 1'b1, 32'hFF000000},
      '{FMT_BC3, 64'hDB6DB6DB6DB68080, 64'h0, 1'b1, 32'h00000000},
      // BC3 eight-step and six-step with mixed indices
      '{FMT_BC3, 64'hFAC688D1F9A300FF, 64'h72D4E41B_4A69B2C5, 1'b0, 32'h0},
      '{FMT_BC3, 64'h05397726FB1AC810, 64'h9C3E6B01_FFDF0820, 1'b0, 32'h0},
      '{FMT_BC3, 64'hFFFFFFFFFFFFFFFF, 64'hFFFFFFFFFFFFFFFF, 1'b1, 32'hFFFFFFFF},
      '{FMT_BC3, 64'h2492492492491040, 64'h55555555_7BEF8410, 1'b0, 32'h0}
   };

   localparam logic [1:0] PHASE_FORMATS [RANDOM_PHASES] = '{
      FMT_BC3, FMT_BC1, FMT_BC2, FMT_CODE3, FMT_BC2, FMT_BC1, FMT_BC3, FMT_CODE3
   };

   logic         clock;
   logic         reset;
   logic         csr_we;
   logic [1:0]   csr_wdata;
   logic         req_tvalid;
   logic         req_tready;
   logic [127:0] req_tdata;   // alpha_half, color_half
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [39:0]  rsp_tdata;   // red, green, blue, alpha, texel_index, pad
   logic         rsp_tlast;   // last_texel

   texel_type  pending_texels [$];
   logic [1:0] fmt_reg;
   logic       send_idle;
   logic       recv_idle;
   logic       hold_req;
   int         error_count;
   int         blocks_sent;
   int         texels_seen;
   int         holds_done;
   int         quiet_cycles;

   dxt_texture_block_decode uut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      clock = 1'b0;
      #CLK_LOW;
      clock = 1'b1;
      #CLK_HIGH;
   end

   // Decode one block at the current format and queue its 16 texels
   function automatic void decode_block(input logic [63:0] ah, input logic [63:0] ch);
      fmt_type     fmt;
      logic [15:0] c0;
      logic [15:0] c1;
      logic        four_color;
      int          ep [2][3];
      int          pal [4][4];
      int          apal [8];
      int          a0;
      int          a1;
      int          ci;
      texel_type   t;
      fmt = (fmt_reg == FMT_BC2 || fmt_reg == FMT_BC3) ? fmt_type'(fmt_reg) : FMT_BC1;
      c0 = ch[15:0];
      c1 = ch[31:16];
      four_color = (fmt != FMT_BC1) || (c0 > c1);

      // 565 endpoints to 8 bits per channel, truncating
      ep[0][0] = int'(c0[15:11]) * 255 / 31;
      ep[0][1] = int'(c0[10:5]) * 255 / 63;
      ep[0][2] = int'(c0[4:0]) * 255 / 31;
      ep[1][0] = int'(c1[15:11]) * 255 / 31;
      ep[1][1] = int'(c1[10:5]) * 255 / 63;
      ep[1][2] = int'(c1[4:0]) * 255 / 31;

      // color palette
      for (int j = 0; j < 3; j++) begin
         pal[0][j] = ep[0][j];
         pal[1][j] = ep[1][j];
         pal[2][j] = four_color ? (2 * ep[0][j] + ep[1][j]) / 3 : (ep[0][j] + ep[1][j]) / 2;
         pal[3][j] = four_color ? (ep[0][j] + 2 * ep[1][j]) / 3 : 0;
      end
      pal[0][3] = 255;
      pal[1][3] = 255;
      pal[2][3] = 255;
      pal[3][3] = four_color ? 255 : 0;

      // interpolated alpha palette
      a0 = int'(ah[7:0]);
      a1 = int'(ah[15:8]);
      apal[0] = a0;
      apal[1] = a1;
      if (a0 > a1) begin
         for (int i = 1; i < 7; i++)
            apal[i + 1] = ((7 - i) * a0 + i * a1) / 7;
      end else begin
         for (int i = 1; i < 5; i++)
            apal[i + 1] = ((5 - i) * a0 + i * a1) / 5;
         apal[6] = 0;
         apal[7] = 255;
      end

      for (int k = 0; k < 16; k++) begin
         ci = int'(ch[32 + 2 * k +: 2]);
         t.red   = 8'(pal[ci][0]);
         t.green = 8'(pal[ci][1]);
         t.blue  = 8'(pal[ci][2]);
         case (fmt)
            FMT_BC2: t.alpha = 8'(int'(ah[4 * k +: 4]) * 17);
            FMT_BC3: t.alpha = 8'(apal[ah[16 + 3 * k +: 3]]);
            default: t.alpha = 8'(pal[ci][3]);
         endcase
         t.pos  = 4'(k);
         t.last = (k == 15);
         pending_texels.push_back(t);
      end
   endfunction

   function automatic void check_field(input string name, input logic [7:0] expv,
                                       input logic [7:0] actv);
      if (expv !== actv) begin
         if (error_count < MAX_REPORTS)
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, expv, actv);
         error_count++;
      end
   endfunction

   // Wait until the decoder is empty, then write the format register
   task automatic set_format(input logic [1:0] code);
      req_tvalid <= 1'b0;
      while (pending_texels.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= code;
      @(posedge clock);
      csr_we  <= 1'b0;
      fmt_reg = code;
   endtask

   // Offer one block, wait for its transfer, queue what it must decode to
   task automatic send_block(input logic [63:0] ah, input logic [63:0] ch,
                             input logic known, input logic [31:0] rgba);
      int        gap;
      texel_type t;
      gap = send_idle ? $urandom_range(0, 9) : 0;
      repeat (gap) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {ch, ah};
      do @(posedge clock); while (!req_tready);
      blocks_sent++;
      if (known) begin
         for (int k = 0; k < 16; k++) begin
            t.red   = rgba[7:0];
            t.green = rgba[15:8];
            t.blue  = rgba[23:16];
            t.alpha = rgba[31:24];
            t.pos   = 4'(k);
            t.last  = (k == 15);
            pending_texels.push_back(t);
         end
      end else begin
         decode_block(ah, ch);
      end
   endtask

   // Texel receiver: random stalls, plus one long hold-off on request
   initial begin : texel_sink
      int gap;
      int count;
      count = 0;
      rsp_tready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (count % 40 == 0)
            recv_idle = ($urandom_range(0, 2) != 0);
         if (hold_req) begin
            hold_req = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            holds_done++;
         end
         gap = recv_idle ? $urandom_range(0, 9) : 0;
         repeat (gap) begin
            rsp_tready <= 1'b0;
            @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         count++;
      end
   end

   // Texel check and stall watchdog
   always @(posedge clock) begin : texel_monitor
      texel_type exp_t;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            texels_seen++;
            if (pending_texels.size() == 0) begin
               if (error_count < MAX_REPORTS)
                  $display("%0t: unexpected texel: expected none, actual data %h last %b",
                           $time, rsp_tdata, rsp_tlast);
               error_count++;
            end else begin
               exp_t = pending_texels.pop_front();
               check_field("red", exp_t.red, rsp_tdata[7:0]);
               check_field("green", exp_t.green, rsp_tdata[15:8]);
               check_field("blue", exp_t.blue, rsp_tdata[23:16]);
               check_field("alpha", exp_t.alpha, rsp_tdata[31:24]);
               check_field("texel_index", 8'(exp_t.pos), 8'(rsp_tdata[35:32]));
               check_field("last_texel", 8'(exp_t.last), 8'(rsp_tlast));
            end
         end

         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles, %0d texels outstanding",
                     $time, STALL_LIMIT, pending_texels.size());
            $display("** dxt_texture_block_decode: FAILED **");
            $finish;
         end
      end
   end

   initial begin : stimulus
      logic [63:0] ah;
      logic [63:0] ch;
      reset      <= 1'b1;
      csr_we     <= 1'b0;
      csr_wdata  <= FMT_BC1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      fmt_reg     = FMT_BC1;
      send_idle   = 1'b1;
      recv_idle   = 1'b1;
      hold_req    = 1'b0;
      error_count = 0;
      blocks_sent = 0;
      texels_seen = 0;
      holds_done  = 0;
      quiet_cycles = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed blocks, grouped by format
      for (int v = 0; v < NUM_VECTORS; v++) begin
         if (VECTORS[v].fmt != fmt_reg)
            set_format(VECTORS[v].fmt);
         send_block(VECTORS[v].alpha_half, VECTORS[v].color_half,
                    VECTORS[v].known, VECTORS[v].rgba);
      end

      // random blocks, one format per phase
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         set_format(PHASE_FORMATS[p]);
         if (p == PRESSURE_PHASE) begin
            // sender streams back to back while the receiver holds off
            send_idle = 1'b0;
            hold_req  = 1'b1;
         end else begin
            send_idle = ($urandom_range(0, 2) != 0);
         end
         for (int n = 0; n < BLOCKS_PER_PHASE; n++) begin
            ah = {$urandom, $urandom};
            ch = {$urandom, $urandom};
            case ($urandom_range(0, 7))
               0: ch[31:16] = ch[15:0];        // equal color endpoints
               1: ah[15:8]  = ah[7:0];         // equal alpha endpoints
               2: ch[15:0]  = ch[31:16] + 16'd1;
               default: ;
            endcase
            send_block(ah, ch, 1'b0, 32'h0);
         end
      end

      // drain
      req_tvalid <= 1'b0;
      while (pending_texels.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Run covered %0d blocks and %0d texels in BC1, BC2, BC3 and format code 3,",
               blocks_sent, texels_seen);
      $display("with random stalls on both sides and %0d receiver hold-off(s) of %0d cycles.",
               holds_done, HOLD_CYCLES);
      if (error_count == 0 && pending_texels.size() == 0) begin
         $display("** dxt_texture_block_decode: PASSED **");
      end else begin
         $display("** dxt_texture_block_decode: FAILED **");
      end
      $finish;
   end

endmodule

// File: files.f
+incdir+hdl
hdl/dxt_pkg.sv
hdl/dxt_color_lane.sv
hdl/dxt_alpha_lane.sv
hdl/dxt_texel_merge.sv
hdl/dxt_texture_block_decode.sv
test/dxt_texture_block_decode_tb.sv
